// File: hdl/hri_pkg.sv
`default_nettype none

package hri_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned DigitW = 9;
  localparam int unsigned DimW = 6;
  localparam int unsigned TableSize = 64;
  localparam int unsigned MaxDigits = 64;
  localparam int unsigned CntW = 7;
  localparam int unsigned AddrW = 6;
  localparam int unsigned DivRadixBits = 8;
  localparam int unsigned DivSteps = WordW / DivRadixBits;
  localparam int unsigned IterW = 3;
  localparam int unsigned PcW = 3;
  localparam int unsigned OutW = 32;

  localparam logic [DigitW-1:0] PrimeTable [TableSize] = '{
    9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
    9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
    9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
    9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
    9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
    9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
    9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
    9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
  };

  localparam logic [PcW-1:0] StepIdle    = 3'd0;
  localparam logic [PcW-1:0] StepCheck   = 3'd1;
  localparam logic [PcW-1:0] StepExtract = 3'd2;
  localparam logic [PcW-1:0] StepPush    = 3'd3;
  localparam logic [PcW-1:0] StepPop     = 3'd4;
  localparam logic [PcW-1:0] StepLoad    = 3'd5;
  localparam logic [PcW-1:0] StepFold    = 3'd6;
  localparam logic [PcW-1:0] StepOut     = 3'd7;

  typedef enum logic [1:0] {
    WAIT_NONE  = 2'd0,
    WAIT_INPUT = 2'd1,
    WAIT_DIV   = 2'd2,
    WAIT_OUT   = 2'd3
  } wait_e;

  typedef enum logic [1:0] {
    BR_NEXT     = 2'd0,
    BR_ALWAYS   = 2'd1,
    BR_Q_ZERO   = 2'd2,
    BR_CNT_ZERO = 2'd3
  } branch_e;

  typedef struct packed {
    wait_e             wait_sel;
    branch_e           branch;
    logic [PcW-1:0]    target;
    logic              load_in;
    logic              div;
    logic              push;
    logic              pop;
    logic              load_fold;
    logic              out_wr;
  } uword_t;

  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic div;
    logic push;
    logic pop;
    logic load_fold;
    logic out_wr;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_blocked;
    logic q_zero;
    logic cnt_zero;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

// File: hdl/hri_sequencer.sv
`default_nettype none

module hri_sequencer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire hri_pkg::status_t status_i,
  output hri_pkg::ctrl_t       ctrl_o
);

  logic [hri_pkg::PcW-1:0] pc_q, pc_d;
  hri_pkg::uword_t uw;
  logic hold;
  logic take;

  always_comb begin
    uw = hri_pkg::uword_t'('0);
    case (pc_q)
      hri_pkg::StepIdle: begin
        uw.wait_sel = hri_pkg::WAIT_INPUT;
        uw.load_in = 1'b1;
      end
      hri_pkg::StepCheck: begin
        uw.branch = hri_pkg::BR_Q_ZERO;
        uw.target = hri_pkg::StepPop;
      end
      hri_pkg::StepExtract: begin
        uw.wait_sel = hri_pkg::WAIT_DIV;
        uw.div = 1'b1;
      end
      hri_pkg::StepPush: begin
        uw.branch = hri_pkg::BR_ALWAYS;
        uw.target = hri_pkg::StepCheck;
        uw.push = 1'b1;
      end
      hri_pkg::StepPop: begin
        uw.branch = hri_pkg::BR_CNT_ZERO;
        uw.target = hri_pkg::StepOut;
        uw.pop = 1'b1;
      end
      hri_pkg::StepLoad: begin
        uw.load_fold = 1'b1;
      end
      hri_pkg::StepFold: begin
        uw.wait_sel = hri_pkg::WAIT_DIV;
        uw.branch = hri_pkg::BR_ALWAYS;
        uw.target = hri_pkg::StepPop;
        uw.div = 1'b1;
      end
      hri_pkg::StepOut: begin
        uw.wait_sel = hri_pkg::WAIT_OUT;
        uw.out_wr = 1'b1;
      end
      default: begin
        uw.branch = hri_pkg::BR_ALWAYS;
        uw.target = hri_pkg::StepIdle;
      end
    endcase
  end

  always_comb begin
    case (uw.wait_sel)
      hri_pkg::WAIT_INPUT: hold = !status_i.in_valid;
      hri_pkg::WAIT_DIV:   hold = !status_i.div_last;
      hri_pkg::WAIT_OUT:   hold = status_i.out_blocked;
      default:             hold = 1'b0;
    endcase
    case (uw.branch)
      hri_pkg::BR_ALWAYS:   take = 1'b1;
      hri_pkg::BR_Q_ZERO:   take = status_i.q_zero;
      hri_pkg::BR_CNT_ZERO: take = status_i.cnt_zero;
      default:              take = 1'b0;
    endcase
    if (hold) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + 3'd1;
    end
  end

  always_comb begin
    ctrl_o.in_ready  = (pc_q == hri_pkg::StepIdle);
    ctrl_o.load_in   = uw.load_in & !hold;
    ctrl_o.div       = uw.div;
    ctrl_o.push      = uw.push & !hold;
    ctrl_o.pop       = uw.pop & !hold;
    ctrl_o.load_fold = uw.load_fold & !hold;
    ctrl_o.out_wr    = uw.out_wr & !hold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= hri_pkg::StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/hri_datapath.sv
`default_nettype none

module hri_datapath #(
  parameter int unsigned NUM_DIMS  = 64,
  parameter int unsigned FRAC_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire hri_pkg::ctrl_t                ctrl_i,
  input  wire logic [hri_pkg::DimW-1:0]      dimension_i,
  input  wire logic [hri_pkg::WordW-1:0]     seq_index_i,
  output hri_pkg::status_t                   status_o,
  output logic [hri_pkg::OutW-1:0]           quasi_value_o
);

  localparam int unsigned LastDim = NUM_DIMS - 1;

  logic [hri_pkg::DigitW-1:0] base_q;
  logic [hri_pkg::WordW-1:0]  q_q, q_d;
  logic [hri_pkg::DigitW-1:0] rem_q, rem_d;
  logic [hri_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [hri_pkg::IterW-1:0]  iter_q;
  logic [hri_pkg::DigitW-1:0] rd_q;
  logic [hri_pkg::DigitW-1:0] digit_mem [hri_pkg::MaxDigits];
  logic [hri_pkg::DimW-1:0]   dim_sel;
  logic [hri_pkg::CntW-1:0]   cnt_dec;
  logic                       pop_ok;
  logic [hri_pkg::DigitW:0]   trial;
  logic [hri_pkg::DigitW-1:0] rem_v;
  logic [hri_pkg::DivRadixBits-1:0] qbits;

  always_comb begin
    if (32'(dimension_i) > LastDim) begin
      dim_sel = hri_pkg::DimW'(LastDim);
    end else begin
      dim_sel = dimension_i;
    end
  end

  always_comb begin
    rem_v = (iter_q == '0) ? '0 : rem_q;
    qbits = '0;
    trial = '0;
    for (int k = 0; k < int'(hri_pkg::DivRadixBits); k++) begin
      trial = {rem_v, q_q[hri_pkg::WordW-1-k]};
      if (trial >= {1'b0, base_q}) begin
        trial = trial - {1'b0, base_q};
        qbits[hri_pkg::DivRadixBits-1-k] = 1'b1;
      end
      rem_v = trial[hri_pkg::DigitW-1:0];
    end
    rem_d = rem_v;
  end

  assign cnt_dec = cnt_q - 7'd1;
  assign pop_ok = ctrl_i.pop && (cnt_q != '0);

  always_comb begin
    q_d = q_q;
    cnt_d = cnt_q;
    if (ctrl_i.load_in) begin
      q_d = seq_index_i;
      cnt_d = '0;
    end
    if (ctrl_i.div) begin
      q_d = {q_q[hri_pkg::WordW-hri_pkg::DivRadixBits-1:0], qbits};
    end
    if (ctrl_i.load_fold) begin
      q_d = q_q | (hri_pkg::WordW'(rd_q) << FRAC_BITS);
    end
    if (ctrl_i.push) begin
      cnt_d = cnt_q + 7'd1;
    end
    if (pop_ok) begin
      cnt_d = cnt_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      iter_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (ctrl_i.div) begin
        iter_q <= iter_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    if (ctrl_i.load_in) begin
      base_q <= hri_pkg::PrimeTable[dim_sel];
    end
    if (ctrl_i.div) begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      digit_mem[cnt_q[hri_pkg::AddrW-1:0]] <= rem_q;
    end
    if (pop_ok) begin
      rd_q <= digit_mem[cnt_dec[hri_pkg::AddrW-1:0]];
    end
  end

  always_comb begin
    status_o.in_valid    = 1'b0;
    status_o.out_blocked = 1'b0;
    status_o.q_zero      = (q_q == '0);
    status_o.cnt_zero    = (cnt_q == '0);
    status_o.div_last    = (iter_q == hri_pkg::IterW'(hri_pkg::DivSteps - 1));
  end

  assign quasi_value_o = q_q[hri_pkg::OutW-1:0];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= hri_pkg::CntW'(hri_pkg::MaxDigits))
    else $error("digit count beyond stack depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> (cnt_q < hri_pkg::CntW'(hri_pkg::MaxDigits)) && (rem_q < base_q))
    else $error("digit push with full stack or remainder not below base");

endmodule

`default_nettype wire

// File: hdl/halton_radical_inverse_unit.sv
// Halton radical inverse unit.
// An item on the input channel (in_valid_i, in_stall_o) carries a dimension and a
// 64-bit sequence index. The base is the prime picked by the dimension; dimensions
// at or beyond NUM_DIMS use the last table entry. The result item on the output
// channel (out_valid_o, out_stall_i) is the index's base digits mirrored about the
// radix point, scaled by 2^FRAC_BITS and truncated, low 32 bits.
// A small microcode program drives one shared divider that retires 8 quotient bits
// per cycle to divide the 64-bit working word by the base.
// Digits are pulled off one division at a time into a 64-entry stack, then popped
// and folded back, again one division each. The result is written once the last
// digit is folded back, and the next item is taken in the cycle after that, so
// the unit works on one item at a time.
// The result sits in an output register, so a stalled receiver does not stop the
// next item from being accepted; only a second result waits for the register.
// Reset clears the step counter and the valid flag; no item is held across reset.
`default_nettype none

module halton_radical_inverse_unit #(
  parameter int unsigned NUM_DIMS  = 64,
  parameter int unsigned FRAC_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [5:0]  dimension_i,
  input  wire logic [63:0] seq_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      quasi_value_o
);

  hri_pkg::ctrl_t   ctrl;
  hri_pkg::status_t dp_status;
  hri_pkg::status_t status;
  logic [hri_pkg::OutW-1:0] dp_value;
  logic [hri_pkg::OutW-1:0] out_q;
  logic out_valid_q;

  always_comb begin
    status = dp_status;
    status.in_valid = in_valid_i;
    status.out_blocked = out_valid_q && out_stall_i;
  end

  hri_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  hri_datapath #(
    .NUM_DIMS  (NUM_DIMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .dimension_i   (dimension_i),
    .seq_index_i   (seq_index_i),
    .status_o      (dp_status),
    .quasi_value_o (dp_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_wr) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_wr) begin
      out_q <= dp_value;
    end
  end

  assign in_stall_o    = !ctrl.in_ready;
  assign out_valid_o   = out_valid_q;
  assign quasi_value_o = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while the previous item is still in work");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_wr |-> in_stall_o && !(out_valid_q && out_stall_i))
    else $error("result written outside an item or over a held result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(quasi_value_o))
    else $error("held result lost or changed");

endmodule

`default_nettype wire
